/* rtl/dtsi_pkg.sv */
// Shared types, codes and constants for the decimal text to signed integer converter.
package dtsi_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned UBOUND_W    = 63;

  localparam logic [CFG_INDEX_W-1:0] CFG_LOWER_BOUND     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_UPPER_BOUND     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GROUP_SEPARATOR = 2'd2;

  localparam logic [VALUE_W-1:0]  LOWER_BOUND_RST = 64'h8000_0000_0000_0000;
  localparam logic [UBOUND_W-1:0] UPPER_BOUND_RST = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [7:0]          SEPARATOR_RST   = 8'd0;

  localparam logic [7:0] CHAR_NUL   = 8'd0;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NODIGITS = 2'd1;
  localparam status_t ST_OVERFLOW = 2'd2;
  localparam status_t ST_INVALID  = 2'd3;

  // One classified text byte as it travels from the front end to the back end.
  typedef struct packed {
    logic       is_ws;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_nul;
    logic       is_minus;
    logic       is_plus;
    logic       is_sep;
    logic       last;
  } char_class_t;

endpackage

/* rtl/dtsi_front.sv */
// Front end: accepts text bytes and classifies each one for the back end.
module dtsi_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_char_code,
  input  logic                 in_is_last,
  input  logic [7:0]           group_separator,
  input  logic                 q_full,
  output logic                 q_push,
  output dtsi_pkg::char_class_t q_item
);

  logic [3:0] digit_off;

  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;
  assign digit_off = 4'(in_char_code - dtsi_pkg::CHAR_ZERO);

  always_comb begin
    q_item.is_ws    = ((in_char_code >= dtsi_pkg::CHAR_TAB) && (in_char_code <= dtsi_pkg::CHAR_CR))
                      || (in_char_code == dtsi_pkg::CHAR_SPACE);
    q_item.is_digit = (in_char_code >= dtsi_pkg::CHAR_ZERO) &&
                      (in_char_code <= dtsi_pkg::CHAR_NINE);
    q_item.digit    = digit_off;
    q_item.is_nul   = (in_char_code == dtsi_pkg::CHAR_NUL);
    q_item.is_minus = (in_char_code == dtsi_pkg::CHAR_MINUS);
    q_item.is_plus  = (in_char_code == dtsi_pkg::CHAR_PLUS);
    // A separator of zero means none is configured.
    q_item.is_sep   = (group_separator != dtsi_pkg::CHAR_NUL) &&
                      (in_char_code == group_separator);
    q_item.last     = in_is_last;
  end

endmodule

/* rtl/dtsi_queue.sv */
// Short queue of classified bytes between the front end and the back end.
module dtsi_queue #(
  parameter int unsigned DEPTH = dtsi_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  dtsi_pkg::char_class_t push_item,
  output logic                  full,
  input  logic                  pop,
  output logic                  pop_valid,
  output dtsi_pkg::char_class_t pop_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  dtsi_pkg::char_class_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/dtsi_back.sv */
// Back end: runs the parse state machine, accumulates digits and registers the result.
module dtsi_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  dtsi_pkg::char_class_t             q_item,
  output logic                              q_pop,
  input  logic signed [dtsi_pkg::VALUE_W-1:0] lower_bound,
  input  logic [dtsi_pkg::UBOUND_W-1:0]     upper_bound,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [dtsi_pkg::VALUE_W-1:0] out_parsed_value,
  output dtsi_pkg::status_t                 out_status
);

  localparam int unsigned EXT_W = dtsi_pkg::VALUE_W + 4;

  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_DIGITS = 3'd2;
  localparam logic [2:0] PH_TRAIL  = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  logic [2:0]                          phase_r, phase_nxt;
  logic                                neg_r, neg_nxt;
  logic signed [dtsi_pkg::VALUE_W-1:0] acc_r, acc_nxt;
  dtsi_pkg::status_t                   err_r, err_nxt;

  logic                                out_valid_r;
  logic signed [dtsi_pkg::VALUE_W-1:0] out_value_r;
  dtsi_pkg::status_t                   out_status_r;

  logic                    take_out;
  logic signed [EXT_W-1:0] acc_x, acc_times10, dv_x, cand;
  logic signed [EXT_W-1:0] lb_x, ub_x;
  logic                    fits, use_neg, run_byte;
  dtsi_pkg::status_t       final_status;

  assign take_out = !out_valid_r || !out_stall;
  // Non-final bytes keep flowing even while a finished result waits.
  assign q_pop    = q_valid && (!q_item.last || take_out);

  // Bound check done on the widened product: acc*10 +/- digit compared with the bound.
  assign acc_x       = {{4{acc_r[dtsi_pkg::VALUE_W-1]}}, acc_r};
  assign acc_times10 = (acc_x <<< 3) + (acc_x <<< 1);
  assign dv_x        = $signed({{(EXT_W-4){1'b0}}, q_item.digit});
  assign lb_x        = {{4{lower_bound[dtsi_pkg::VALUE_W-1]}}, lower_bound};
  assign ub_x        = $signed({{(EXT_W-dtsi_pkg::UBOUND_W){1'b0}}, upper_bound});

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    err_nxt   = err_r;
    run_byte  = 1'b0;
    use_neg   = neg_r;

    if (err_r == dtsi_pkg::ST_OK) begin
      unique case (phase_r)
        PH_LEAD: begin
          if (q_item.is_ws) begin
            phase_nxt = PH_LEAD;
          end else if (q_item.is_minus) begin
            neg_nxt   = 1'b1;
            phase_nxt = PH_SIGN;
          end else if (q_item.is_plus) begin
            phase_nxt = PH_SIGN;
          end else if (q_item.is_digit) begin
            phase_nxt = PH_DIGITS;
            run_byte  = 1'b1;
          end else begin
            err_nxt = dtsi_pkg::ST_NODIGITS;
          end
        end
        PH_SIGN: begin
          if (q_item.is_digit) begin
            phase_nxt = PH_DIGITS;
            run_byte  = 1'b1;
          end else begin
            err_nxt = dtsi_pkg::ST_NODIGITS;
          end
        end
        PH_DIGITS: begin
          run_byte = 1'b1;
        end
        PH_TRAIL: begin
          if (q_item.is_nul) begin
            phase_nxt = PH_DONE;
          end else if (!q_item.is_ws) begin
            err_nxt = dtsi_pkg::ST_INVALID;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end

    cand = use_neg ? (acc_times10 - dv_x) : (acc_times10 + dv_x);
    fits = use_neg ? (cand >= lb_x) : (cand <= ub_x);

    if (run_byte && !q_item.is_sep) begin
      if (q_item.is_digit) begin
        if (fits) begin
          acc_nxt = cand[dtsi_pkg::VALUE_W-1:0];
        end else begin
          err_nxt = dtsi_pkg::ST_OVERFLOW;
        end
      end else if (q_item.is_ws) begin
        phase_nxt = PH_TRAIL;
      end else if (q_item.is_nul) begin
        phase_nxt = PH_DONE;
      end else begin
        err_nxt = dtsi_pkg::ST_INVALID;
      end
    end

    final_status = err_nxt;
    if ((err_nxt == dtsi_pkg::ST_OK) && ((phase_nxt == PH_LEAD) || (phase_nxt == PH_SIGN))) begin
      final_status = dtsi_pkg::ST_NODIGITS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      neg_r       <= 1'b0;
      acc_r       <= '0;
      err_r       <= dtsi_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop && q_item.last) begin
        phase_r     <= PH_LEAD;
        neg_r       <= 1'b0;
        acc_r       <= '0;
        err_r       <= dtsi_pkg::ST_OK;
        out_valid_r <= 1'b1;
      end else begin
        if (q_pop) begin
          phase_r <= phase_nxt;
          neg_r   <= neg_nxt;
          acc_r   <= acc_nxt;
          err_r   <= err_nxt;
        end
        if (!out_stall) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      out_status_r <= final_status;
      out_value_r  <= (final_status == dtsi_pkg::ST_OK) ? acc_nxt : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_parsed_value = out_value_r;
  assign out_status       = out_status_r;

endmodule

/* rtl/decimal_text_to_signed_int.sv */
// Top level of the streaming bounded decimal text to signed integer converter.
//
//   Channel   Direction  Handshake            Payload
//   in_       input      in_valid/in_stall    in_char_code, in_is_last
//   out_      output     out_valid/out_stall  out_parsed_value, out_status
//   cfg_      input      cfg_we               cfg_index, cfg_data
//
// One byte per cycle is accepted while in_stall is low; the back end retires one
// queued byte per cycle, bound by the single multiply-by-ten, add and compare on
// the accumulator, save a final byte held by an output stall. A final byte is
// queued first; its result and out_valid are registered when the back end pops it.
// Reset (rst_n low, synchronous) restores the bounds, clears the separator and
// empties the queue. An output stall holds only final bytes; the queue fills and
// then raises in_stall.
module decimal_text_to_signed_int #(
  parameter int unsigned QUEUE_DEPTH = dtsi_pkg::QUEUE_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            in_char_code,
  input  logic                                  in_is_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [dtsi_pkg::VALUE_W-1:0]   out_parsed_value,
  output dtsi_pkg::status_t                     out_status,
  input  logic                                  cfg_we,
  input  logic [dtsi_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [dtsi_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic signed [dtsi_pkg::VALUE_W-1:0] lower_bound_r;
  logic [dtsi_pkg::UBOUND_W-1:0]       upper_bound_r;
  logic [7:0]                          separator_r;

  logic                  q_full, q_push, q_pop, q_valid;
  dtsi_pkg::char_class_t push_item, pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_bound_r <= dtsi_pkg::LOWER_BOUND_RST;
      upper_bound_r <= dtsi_pkg::UPPER_BOUND_RST;
      separator_r   <= dtsi_pkg::SEPARATOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dtsi_pkg::CFG_LOWER_BOUND:     lower_bound_r <= cfg_data;
        dtsi_pkg::CFG_UPPER_BOUND:     upper_bound_r <= cfg_data[dtsi_pkg::UBOUND_W-1:0];
        dtsi_pkg::CFG_GROUP_SEPARATOR: separator_r   <= cfg_data[7:0];
        default: begin
          separator_r <= separator_r;
        end
      endcase
    end
  end

  dtsi_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .in_is_last      (in_is_last),
    .group_separator (separator_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (push_item)
  );

  dtsi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (pop_item)
  );

  dtsi_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (pop_item),
    .q_pop            (q_pop),
    .lower_bound      (lower_bound_r),
    .upper_bound      (upper_bound_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_parsed_value (out_parsed_value),
    .out_status       (out_status)
  );

endmodule
